/* hdl/mdpw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpw_pkg: shared definitions of the multi-depth pixel writer
// Depth mode codes, register indexes, byte constants and the queue entry type.
// ----------------------------------------------------------------------------
package mdpw_pkg;

  localparam int DIM_W   = 10;          // width / height register bits
  localparam int COORD_W = 16;          // pixel coordinate bits
  localparam int ADDR_W  = 16;          // byte address bits
  localparam int PROD_W  = 2 * DIM_W;   // stride * row product bits
  localparam int MODE_W  = 3;
  localparam int CIDX_W  = 2;           // configuration index bits
  localparam int Q_DEPTH = 4;           // default decoupling queue depth

  // depth modes
  localparam logic [MODE_W-1:0] MODE_MONO   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TWO    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FOUR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MODEX  = 3'd4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_DEPTH_MODE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT     = 2'd2;

  // configuration reset values
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd480;

  // byte constants
  localparam logic [7:0] REP_TWO   = 8'h55;
  localparam logic [7:0] MASK_TWO  = 8'hC0;
  localparam logic [7:0] MASK_MONO = 8'h80;
  localparam logic [7:0] MASK_FULL = 8'hFF;

  // one classified pixel, passed from front to back
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        xl;      // low bits of the column
    logic [7:0]        colour;
  } qent_t;

  localparam int QENT_W = $bits(qent_t);

endpackage

/* hdl/mdpw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpw_front: configuration, clipping and address computation
// Holds the configuration registers, drops clipped pixels and undefined
// modes, and pushes one classified entry per kept pixel into the queue.
// ----------------------------------------------------------------------------
module mdpw_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdpw_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [mdpw_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mdpw_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [mdpw_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [7:0]                      in_colour,
  output logic                            q_push,
  input  logic                            q_ready,
  output mdpw_pkg::qent_t                 q_data
);

  logic [mdpw_pkg::MODE_W-1:0]  mode_r;
  logic [mdpw_pkg::DIM_W-1:0]   width_r;
  logic [mdpw_pkg::DIM_W-1:0]   height_r;

  logic                         s1_valid_r, s1_valid_nxt;
  logic [mdpw_pkg::MODE_W-1:0]  s1_mode_r;
  logic [mdpw_pkg::ADDR_W-1:0]  s1_prod_r;
  logic [mdpw_pkg::DIM_W-1:0]   s1_xpart_r;
  logic [2:0]                   s1_xl_r;
  logic [7:0]                   s1_colour_r;

  logic                         in_fire;
  logic                         keep;
  logic                         mode_ok;
  logic [mdpw_pkg::DIM_W-1:0]   stride;
  logic [mdpw_pkg::DIM_W-1:0]   xpart;
  logic [mdpw_pkg::PROD_W-1:0]  prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mdpw_pkg::MODE_MONO;
      width_r  <= mdpw_pkg::WIDTH_RESET;
      height_r <= mdpw_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mdpw_pkg::REG_DEPTH_MODE: mode_r   <= cfg_data[mdpw_pkg::MODE_W-1:0];
        mdpw_pkg::REG_WIDTH:      width_r  <= cfg_data;
        mdpw_pkg::REG_HEIGHT:     height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stride and column part per mode; after clipping x fits in DIM_W bits
  always_comb begin
    mode_ok = 1'b1;
    stride  = width_r;
    xpart   = in_pixel_x[mdpw_pkg::DIM_W-1:0];
    unique case (mode_r) inside
      mdpw_pkg::MODE_MONO, mdpw_pkg::MODE_FOUR: begin
        stride = {3'b000, width_r[mdpw_pkg::DIM_W-1:3]};
        xpart  = {3'b000, in_pixel_x[mdpw_pkg::DIM_W-1:3]};
      end
      mdpw_pkg::MODE_TWO, mdpw_pkg::MODE_MODEX: begin
        stride = {2'b00, width_r[mdpw_pkg::DIM_W-1:2]};
        xpart  = {2'b00, in_pixel_x[mdpw_pkg::DIM_W-1:2]};
      end
      mdpw_pkg::MODE_LINEAR: ;
      default: mode_ok = 1'b0;
    endcase
  end

  assign prod = mdpw_pkg::PROD_W'(stride)
              * mdpw_pkg::PROD_W'(in_pixel_y[mdpw_pkg::DIM_W-1:0]);

  assign keep = mode_ok
             && (in_pixel_x < {{(mdpw_pkg::COORD_W-mdpw_pkg::DIM_W){1'b0}}, width_r})
             && (in_pixel_y < {{(mdpw_pkg::COORD_W-mdpw_pkg::DIM_W){1'b0}}, height_r});

  assign in_ready = !s1_valid_r || q_ready;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = s1_valid_r && q_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_fire && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= mode_r;
      s1_prod_r   <= prod[mdpw_pkg::ADDR_W-1:0];
      s1_xpart_r  <= xpart;
      s1_xl_r     <= in_pixel_x[2:0];
      s1_colour_r <= in_colour;
    end
  end

  always_comb begin
    q_data.mode   = s1_mode_r;
    q_data.addr   = s1_prod_r
                  + {{(mdpw_pkg::ADDR_W-mdpw_pkg::DIM_W){1'b0}}, s1_xpart_r};
    q_data.xl     = s1_xl_r;
    q_data.colour = s1_colour_r;
  end

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !q_ready) |=> s1_valid_r)
    else $error("front stage dropped an entry while the queue was full");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_mode_r == mdpw_pkg::MODE_MONO || s1_mode_r == mdpw_pkg::MODE_TWO
      || s1_mode_r == mdpw_pkg::MODE_FOUR || s1_mode_r == mdpw_pkg::MODE_LINEAR
      || s1_mode_r == mdpw_pkg::MODE_MODEX))
    else $error("undefined depth mode reached the queue");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !q_ready) |-> !in_ready)
    else $error("input taken while the front stage is stalled");

endmodule

/* hdl/mdpw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpw_queue: decoupling queue between front and back
// Small register FIFO of classified pixels; head is read in place.
// ----------------------------------------------------------------------------
module mdpw_queue #(
  parameter int DEPTH = mdpw_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  mdpw_pkg::qent_t  push_data,
  input  logic             pop,
  output logic             head_valid,
  output mdpw_pkg::qent_t  head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mdpw_pkg::qent_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* hdl/mdpw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpw_back: write sequencer and plane tracking
// Turns each queue entry into one or four masked byte writes, tracks the
// selected plane, and holds the current write in the output register.
// ----------------------------------------------------------------------------
module mdpw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  mdpw_pkg::qent_t               head_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mdpw_pkg::ADDR_W-1:0]   out_byte_address,
  output logic [1:0]                    out_plane_index,
  output logic                          out_plane_reselect,
  output logic [7:0]                    out_write_data,
  output logic [7:0]                    out_write_mask,
  output logic                          out_last_write
);

  logic                        out_valid_r;
  logic [mdpw_pkg::ADDR_W-1:0] addr_r;
  logic [1:0]                  plane_r;
  logic                        resel_r;
  logic [7:0]                  data_r;
  logic [7:0]                  mask_r;
  logic                        last_r;

  logic [1:0] pl_r, pl_nxt;       // next plane of a four-plane entry
  logic [1:0] sel_r, sel_nxt;     // remembered plane
  logic       known_r, known_nxt;

  logic       load;
  logic       uses_plane;
  logic [1:0] plane;
  logic       resel;
  logic [7:0] data;
  logic [7:0] mask;
  logic       last;
  logic [3:0] c_lo;

  assign c_lo = head_data.colour[3:0];
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && last;

  always_comb begin
    uses_plane = 1'b0;
    plane      = 2'd0;
    data       = head_data.colour;
    mask       = mdpw_pkg::MASK_FULL;
    last       = 1'b1;
    unique case (head_data.mode)
      mdpw_pkg::MODE_MONO: begin
        data = {8{head_data.colour[0]}};
        mask = mdpw_pkg::MASK_MONO >> head_data.xl;
      end
      mdpw_pkg::MODE_TWO: begin
        data = {6'b000000, head_data.colour[1:0]} * mdpw_pkg::REP_TWO;
        mask = mdpw_pkg::MASK_TWO >> {head_data.xl[1:0], 1'b0};
      end
      mdpw_pkg::MODE_FOUR: begin
        uses_plane = 1'b1;
        plane      = pl_r;
        data       = {8{c_lo[pl_r]}};
        mask       = mdpw_pkg::MASK_MONO >> head_data.xl;
        last       = (pl_r == 2'd3);
      end
      mdpw_pkg::MODE_MODEX: begin
        uses_plane = 1'b1;
        plane      = head_data.xl[1:0];
      end
      default: ;   // linear: colour byte, full mask
    endcase
    resel = uses_plane && (!known_r || plane != sel_r);
  end

  always_comb begin
    pl_nxt    = pl_r;
    sel_nxt   = sel_r;
    known_nxt = known_r;
    if (load) begin
      pl_nxt = last ? 2'd0 : pl_r + 2'd1;
      if (uses_plane) begin
        sel_nxt   = plane;
        known_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pl_r        <= 2'd0;
      sel_r       <= 2'd0;
      known_r     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      pl_r    <= pl_nxt;
      sel_r   <= sel_nxt;
      known_r <= known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r  <= head_data.addr;
      plane_r <= plane;
      resel_r <= resel;
      data_r  <= data;
      mask_r  <= mask;
      last_r  <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_address   = addr_r;
  assign out_plane_index    = plane_r;
  assign out_plane_reselect = resel_r;
  assign out_write_data     = data_r;
  assign out_write_mask     = mask_r;
  assign out_last_write     = last_r;

  a_plane_mid_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (pl_r != 2'd0) |-> (head_valid && head_data.mode == mdpw_pkg::MODE_FOUR))
    else $error("plane sequence active without a four-plane entry at the head");

  a_plane_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pl_r == 2'd3) |=> (pl_r == 2'd0))
    else $error("plane sequence did not restart after plane three");

  a_known_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    known_r |=> known_r)
    else $error("plane knowledge lost");

  a_reselect_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (load && resel) |=> (known_r && sel_r == plane_r))
    else $error("reselect without updating the remembered plane");

endmodule

/* hdl/multi_depth_pixel_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_depth_pixel_writer: pixel to masked framebuffer byte writes
// Clips pixels, computes byte addresses for five depth modes and emits
// masked byte writes with plane selection hints.
// ----------------------------------------------------------------------------
// Each accepted pixel (x, y, colour) becomes masked framebuffer byte writes:
// one write in mono, two-bit packed, eight-bit linear and Mode X, four writes
// (planes 0 to 3) in four-plane mode. Pixels at or beyond the configured width
// or height, and pixels taken while the depth mode is undefined, are dropped
// without any write. The block accepts one pixel per clock while its front
// stage can pass to the queue; the output register issues one write per clock
// while the receiver is ready, so four-plane mode takes a new pixel only as
// its four writes drain, while the other modes sustain one pixel per cycle.
// The first write passes through the front stage, the queue and the output
// register before it appears at the outputs. plane_reselect marks writes
// whose plane differs from the last one selected (or when none was selected
// yet). Configuration writes are always taken and must only happen while idle.
// ----------------------------------------------------------------------------
module multi_depth_pixel_writer #(
  parameter int QUEUE_DEPTH = mdpw_pkg::Q_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,

  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mdpw_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [mdpw_pkg::DIM_W-1:0]    cfg_data,

  // pixel channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mdpw_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [mdpw_pkg::COORD_W-1:0]  in_pixel_y,
  input  logic [7:0]                    in_colour,

  // byte write channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mdpw_pkg::ADDR_W-1:0]   out_byte_address,
  output logic [1:0]                    out_plane_index,
  output logic                          out_plane_reselect,
  output logic [7:0]                    out_write_data,
  output logic [7:0]                    out_write_mask,
  output logic                          out_last_write
);

  // front to queue
  logic            q_push;
  logic            q_ready;
  mdpw_pkg::qent_t q_data;

  // queue to back
  logic            q_pop;
  logic            head_valid;
  mdpw_pkg::qent_t head_data;

  // Classify: clip, decode the mode, multiply stride by row, register.
  mdpw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .in_colour  (in_colour),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_data     (q_data)
  );

  // Buffer classified pixels so a stalled sink does not stall the source
  // until the queue fills, e.g. while four-plane writes drain.
  mdpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_data),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Sequence the writes of the head entry and track the selected plane;
  // drop the head only once its last write is loaded.
  mdpw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_data          (head_data),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte_address   (out_byte_address),
    .out_plane_index    (out_plane_index),
    .out_plane_reselect (out_plane_reselect),
    .out_write_data     (out_write_data),
    .out_write_mask     (out_write_mask),
    .out_last_write     (out_last_write)
  );

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head_valid)
    else $error("back end popped an empty queue");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("front end pushed without room");

endmodule

/* tb/multi_depth_pixel_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_depth_pixel_writer_tb: self-checking bench of the pixel writer
// Drives pixel transfers and register writes, predicts every masked byte
// write in all five depth modes, and checks each write field by field.
// ----------------------------------------------------------------------------
module multi_depth_pixel_writer_tb;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 8;      // three-stage pipeline plus margin
  localparam int RANDOM_PIXELS = 120;

  // Index 3 is not mapped to any register; writes to it must be ignored.
  localparam logic [mdpw_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_CHOKE} sink_mode_t;

  // One predicted framebuffer byte write.
  typedef struct packed {
    logic [mdpw_pkg::ADDR_W-1:0] addr;
    logic [1:0]                  plane;
    logic                        resel;
    logic [7:0]                  data;
    logic [7:0]                  mask;
    logic                        last;
  } byte_write_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mdpw_pkg::CIDX_W-1:0]   cfg_index;
  logic [mdpw_pkg::DIM_W-1:0]    cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [mdpw_pkg::COORD_W-1:0]  in_pixel_x;
  logic [mdpw_pkg::COORD_W-1:0]  in_pixel_y;
  logic [7:0]                    in_colour;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mdpw_pkg::ADDR_W-1:0]   out_byte_address;
  logic [1:0]                    out_plane_index;
  logic                          out_plane_reselect;
  logic [7:0]                    out_write_data;
  logic [7:0]                    out_write_mask;
  logic                          out_last_write;

  // Shadow of the block's registers and plane tracking.
  logic [mdpw_pkg::MODE_W-1:0]   shadow_mode;
  logic [mdpw_pkg::DIM_W-1:0]    shadow_width;
  logic [mdpw_pkg::DIM_W-1:0]    shadow_height;
  logic [1:0]                    shadow_plane;
  logic                          shadow_plane_known;

  byte_write_t         pending_writes[$];

  sink_mode_t          sink_mode = SINK_OPEN;
  logic [7:0]          ready_pat = 8'b1011_0010;
  int                  choke_left = 0;
  bit                  gaps_on;
  int                  burst_left;

  int                  errors;
  int                  cycles;
  int                  pixels_sent;
  int                  pixels_drawn;
  int                  writes_checked;
  int                  reg_writes;
  int                  mode_pixels[8];

  multi_depth_pixel_writer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .in_colour          (in_colour),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte_address   (out_byte_address),
    .out_plane_index    (out_plane_index),
    .out_plane_reselect (out_plane_reselect),
    .out_write_data     (out_write_data),
    .out_write_mask     (out_write_mask),
    .out_last_write     (out_last_write)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Stop a hung run; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d byte writes still outstanding", $time,
               pending_writes.size());
      $display("multi_depth_pixel_writer: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure: change ready at the falling edge only.
  always @(negedge clk) begin
    ready_pat <= {ready_pat[6:0], ready_pat[7]};
    case (sink_mode)
      SINK_OPEN: begin
        out_ready <= 1'b1;
      end
      SINK_RANDOM: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      SINK_PATTERN: begin
        out_ready <= ready_pat[0];
      end
      default: begin
        // long stalls now and then, otherwise open
        if (choke_left != 0) begin
          out_ready  <= 1'b0;
          choke_left <= choke_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) choke_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Compare each write transfer against the oldest predicted write.
  always @(posedge clk) begin : write_checker
    byte_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t ns: unexpected write, expected none, actual addr=%h plane=%0d",
                 $time, out_byte_address, out_plane_index);
        $display("  data=%h mask=%h", out_write_data, out_write_mask);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        check_field("byte_address", want.addr, out_byte_address);
        check_field("plane_index", want.plane, out_plane_index);
        check_field("plane_reselect", want.resel, out_plane_reselect);
        check_field("write_data", want.data, out_write_data);
        check_field("write_mask", want.mask, out_write_mask);
        check_field("last_write", want.last, out_last_write);
        writes_checked++;
      end
    end
  end

  // Flag a reselect when the plane changes or none has been chosen yet.
  function automatic logic claim_plane(input logic [1:0] plane);
    if (shadow_plane_known && plane == shadow_plane) return 1'b0;
    shadow_plane_known = 1'b1;
    shadow_plane       = plane;
    return 1'b1;
  endfunction

  // Queue the byte writes one pixel produces; return how many.
  function automatic int predict_writes(input logic [mdpw_pkg::COORD_W-1:0] x,
                                        input logic [mdpw_pkg::COORD_W-1:0] y,
                                        input logic [7:0] colour);
    int unsigned wu;
    int unsigned xu;
    int unsigned yu;
    byte_write_t w;
    wu = shadow_width;
    xu = x;
    yu = y;
    w  = '0;
    w.last = 1'b1;
    if (xu >= wu || yu >= shadow_height) return 0;
    case (shadow_mode)
      mdpw_pkg::MODE_MONO: begin
        w.addr = 16'((wu / 8) * yu + xu / 8);
        w.mask = mdpw_pkg::MASK_MONO >> x[2:0];
        w.data = {8{colour[0]}};
        pending_writes.push_back(w);
        return 1;
      end
      mdpw_pkg::MODE_TWO: begin
        w.addr = 16'((wu / 4) * yu + xu / 4);
        w.mask = mdpw_pkg::MASK_TWO >> {x[1:0], 1'b0};
        w.data = 8'(colour[1:0] * mdpw_pkg::REP_TWO);
        pending_writes.push_back(w);
        return 1;
      end
      mdpw_pkg::MODE_FOUR: begin
        w.addr = 16'((wu / 8) * yu + xu / 8);
        w.mask = mdpw_pkg::MASK_MONO >> x[2:0];
        for (int p = 0; p < 4; p++) begin
          w.plane = 2'(p);
          w.resel = claim_plane(2'(p));
          w.data  = {8{colour[p]}};
          w.last  = (p == 3);
          pending_writes.push_back(w);
        end
        return 4;
      end
      mdpw_pkg::MODE_LINEAR: begin
        w.addr = 16'(wu * yu + xu);
        w.mask = mdpw_pkg::MASK_FULL;
        w.data = colour;
        pending_writes.push_back(w);
        return 1;
      end
      mdpw_pkg::MODE_MODEX: begin
        w.addr  = 16'((wu / 4) * yu + xu / 4);
        w.plane = x[1:0];
        w.resel = claim_plane(x[1:0]);
        w.mask  = mdpw_pkg::MASK_FULL;
        w.data  = colour;
        pending_writes.push_back(w);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Send one pixel; keep valid up through a burst, drop it for a gap.
  task automatic send_pixel(input logic [mdpw_pkg::COORD_W-1:0] x,
                            input logic [mdpw_pkg::COORD_W-1:0] y,
                            input logic [7:0] colour);
    int produced;
    @(negedge clk);
    in_valid   = 1'b1;
    in_pixel_x = x;
    in_pixel_y = y;
    in_colour  = colour;
    do @(posedge clk); while (!in_ready);
    produced = predict_writes(x, y, colour);
    pixels_sent++;
    if (produced != 0) begin
      pixels_drawn++;
      mode_pixels[shadow_mode]++;
    end
    if (gaps_on && burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Drain: wait for every predicted write, then let dropped pixels retire.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mdpw_pkg::CIDX_W-1:0] index,
                           input logic [mdpw_pkg::DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      mdpw_pkg::REG_DEPTH_MODE: shadow_mode   = data[mdpw_pkg::MODE_W-1:0];
      mdpw_pkg::REG_WIDTH:      shadow_width  = data;
      mdpw_pkg::REG_HEIGHT:     shadow_height = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reprogram all registers; upper data bits of the mode write are noise.
  task automatic set_geometry(input logic [mdpw_pkg::MODE_W-1:0] mode,
                              input logic [mdpw_pkg::DIM_W-1:0] w,
                              input logic [mdpw_pkg::DIM_W-1:0] h);
    wait_idle();
    write_reg(mdpw_pkg::REG_DEPTH_MODE, {7'($urandom), mode});
    write_reg(mdpw_pkg::REG_WIDTH, w);
    write_reg(mdpw_pkg::REG_HEIGHT, h);
  endtask

  // Drop valid first so a held pixel is not taken twice.
  task automatic set_traffic(input sink_mode_t sink, input bit gaps);
    @(negedge clk);
    in_valid   = 1'b0;
    sink_mode  = sink;
    gaps_on    = gaps;
    burst_left = 0;
  endtask

  // Reset values: mono, 640 x 480.
  task automatic test_reset_defaults();
    set_traffic(SINK_OPEN, 1'b0);
    send_pixel(16'd0, 16'd0, 8'h01);
    send_pixel(16'd639, 16'd479, 8'hFE);
    send_pixel(16'd640, 16'd0, 8'h01);
    send_pixel(16'd0, 16'd480, 8'h01);
  endtask

  // Width not a multiple of eight rounds the row stride down.
  task automatic test_mono();
    set_geometry(mdpw_pkg::MODE_MONO, 10'd1023, 10'd1023);
    set_traffic(SINK_RANDOM, 1'b0);
    send_pixel(16'd1022, 16'd1022, 8'h01);
    send_pixel(16'd9, 16'd3, 8'h00);
    send_pixel(16'hFFFF, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_two_bit();
    set_geometry(mdpw_pkg::MODE_TWO, 10'd8, 10'd4);
    set_traffic(SINK_PATTERN, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(16'(i), 16'd1, {6'($urandom), 2'(i)});
    send_pixel(16'd7, 16'd3, 8'hFD);
  endtask

  // Four writes per pixel, reselect on every plane change.
  task automatic test_four_plane();
    set_geometry(mdpw_pkg::MODE_FOUR, 10'd640, 10'd480);
    set_traffic(SINK_RANDOM, 1'b1);
    send_pixel(16'd0, 16'd0, 8'h0F);
    send_pixel(16'd7, 16'd479, 8'hA5);
    send_pixel(16'd639, 16'd1, 8'hF0);
  endtask

  // Large width times row overflows 16 bits and wraps.
  task automatic test_linear();
    set_geometry(mdpw_pkg::MODE_LINEAR, 10'd1023, 10'd1023);
    set_traffic(SINK_OPEN, 1'b0);
    send_pixel(16'd1022, 16'd1022, 8'hFF);
    send_pixel(16'd0, 16'd64, 8'h00);
    send_pixel(16'd5, 16'd0, 8'h5A);
  endtask

  // Same plane twice in a row must not ask for a reselect.
  task automatic test_mode_x();
    set_geometry(mdpw_pkg::MODE_MODEX, 10'd320, 10'd200);
    set_traffic(SINK_CHOKE, 1'b0);
    send_pixel(16'd0, 16'd0, 8'h11);
    send_pixel(16'd4, 16'd0, 8'h22);
    send_pixel(16'd1, 16'd0, 8'h33);
    send_pixel(16'd319, 16'd199, 8'hEE);
  endtask

  // Undefined modes drop pixels; the spare index changes nothing.
  task automatic test_undefined_modes();
    set_traffic(SINK_OPEN, 1'b0);
    for (int m = 5; m < 8; m++) begin
      set_geometry(3'(m), 10'd640, 10'd480);
      send_pixel(16'd1, 16'd1, 8'hFF);
    end
    wait_idle();
    write_reg(REG_SPARE, 10'h3FF);
    write_reg(mdpw_pkg::REG_DEPTH_MODE, {7'd0, mdpw_pkg::MODE_MONO});
    send_pixel(16'd639, 16'd479, 8'h01);
  endtask

  // Zero width or height clips everything.
  task automatic test_zero_dims();
    set_geometry(mdpw_pkg::MODE_LINEAR, 10'd0, 10'd480);
    send_pixel(16'd0, 16'd0, 8'h01);
    set_geometry(mdpw_pkg::MODE_LINEAR, 10'd640, 10'd0);
    send_pixel(16'd0, 16'd0, 8'h01);
  endtask

  // Phases of random geometry, mostly in-range pixels with some noise.
  task automatic test_random_traffic();
    int drawn_start;
    int pick;
    int count;
    logic [mdpw_pkg::MODE_W-1:0]  mode;
    logic [mdpw_pkg::DIM_W-1:0]   w;
    logic [mdpw_pkg::DIM_W-1:0]   h;
    logic [mdpw_pkg::COORD_W-1:0] x;
    logic [mdpw_pkg::COORD_W-1:0] y;
    drawn_start = pixels_drawn;
    while (pixels_drawn - drawn_start < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 19);
      mode = (pick == 0) ? 3'($urandom_range(5, 7)) : 3'(pick % 5);
      case ($urandom_range(0, 9))
        0:       w = 10'd8;
        1:       w = 10'd1023;
        2:       w = 10'($urandom_range(1, 1023));
        default: w = 10'(8 * $urandom_range(1, 127));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 10'd1;
        1:       h = 10'd1023;
        default: h = 10'($urandom_range(1, 1023));
      endcase
      set_geometry(mode, w, h);
      if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, 10'($urandom));
      set_traffic(sink_mode_t'($urandom_range(0, 3)), $urandom_range(0, 2) != 0);
      count = $urandom_range(6, 24);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else begin
          x = 16'($urandom_range(0, w - 1));
          y = 16'($urandom_range(0, h - 1));
        end
        send_pixel(x, y, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = mdpw_pkg::REG_DEPTH_MODE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_colour  = '0;
    gaps_on    = 1'b0;
    burst_left = 0;
    errors     = 0;
    cycles     = 0;
    pixels_sent    = 0;
    pixels_drawn   = 0;
    writes_checked = 0;
    reg_writes     = 0;
    foreach (mode_pixels[i]) mode_pixels[i] = 0;
    // shadow registers start at the reset values
    shadow_mode        = mdpw_pkg::MODE_MONO;
    shadow_width       = mdpw_pkg::WIDTH_RESET;
    shadow_height      = mdpw_pkg::HEIGHT_RESET;
    shadow_plane       = 2'd0;
    shadow_plane_known = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_mono();
    test_two_bit();
    test_four_plane();
    test_linear();
    test_mode_x();
    test_undefined_modes();
    test_zero_dims();
    test_random_traffic();

    wait_idle();
    $display("Sent %0d pixel transfers, %0d drawn (mono %0d, two-bit %0d, four-plane %0d,",
             pixels_sent, pixels_drawn, mode_pixels[mdpw_pkg::MODE_MONO],
             mode_pixels[mdpw_pkg::MODE_TWO], mode_pixels[mdpw_pkg::MODE_FOUR]);
    $display("linear %0d, Mode X %0d); %0d byte writes checked, %0d register writes.",
             mode_pixels[mdpw_pkg::MODE_LINEAR], mode_pixels[mdpw_pkg::MODE_MODEX],
             writes_checked, reg_writes);
    if (errors == 0) begin
      $display("multi_depth_pixel_writer: match");
    end else begin
      $display("multi_depth_pixel_writer: mismatch");
    end
    $finish;
  end

endmodule
